// ----- src/lld_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lld_pkg
// Shared constants for the 3D line to line distance block.
// ----------------------------------------------------------------------------
package lld_pkg;

    localparam int COORD_WIDTH_DEF = 32;  // origin width, signed Q16.16
    localparam int DIR_W           = 16;  // direction width, signed Q1.14
    localparam int SCALE_SH        = 28;  // squared direction scale, 2^28
    localparam int NN_W            = 64;  // squared cross norm, units 2^-56
    localparam int CFG_W           = 32;  // parallel limit register
    localparam int FIFO_DEPTH      = 4;   // queue between front and back
    localparam int FRONT_STAGES    = 5;
    localparam int PRE_STAGES      = 3;   // back stages ahead of the root search

endpackage

`default_nettype wire

// ----- src/lld_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lld_in_if / lld_out_if
// Valid/ready channels carrying line pairs in and distances out.
// ----------------------------------------------------------------------------
interface lld_in_if import lld_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] a_org_x;
    logic signed [COORD_WIDTH-1:0] a_org_y;
    logic signed [COORD_WIDTH-1:0] a_org_z;
    logic signed [DIR_W-1:0]       a_dir_x;
    logic signed [DIR_W-1:0]       a_dir_y;
    logic signed [DIR_W-1:0]       a_dir_z;
    logic signed [COORD_WIDTH-1:0] b_org_x;
    logic signed [COORD_WIDTH-1:0] b_org_y;
    logic signed [COORD_WIDTH-1:0] b_org_z;
    logic signed [DIR_W-1:0]       b_dir_x;
    logic signed [DIR_W-1:0]       b_dir_y;
    logic signed [DIR_W-1:0]       b_dir_z;

    modport source
    (
        output valid, a_org_x, a_org_y, a_org_z, a_dir_x, a_dir_y, a_dir_z,
               b_org_x, b_org_y, b_org_z, b_dir_x, b_dir_y, b_dir_z,
        input  ready
    );
    modport sink
    (
        input  valid, a_org_x, a_org_y, a_org_z, a_dir_x, a_dir_y, a_dir_z,
               b_org_x, b_org_y, b_org_z, b_dir_x, b_dir_y, b_dir_z,
        output ready
    );
endinterface

interface lld_out_if import lld_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
);
    logic                   valid;
    logic                   ready;
    logic [COORD_WIDTH-1:0] distance;
    logic                   is_parallel;

    modport source
    (
        output valid, distance, is_parallel,
        input  ready
    );
    modport sink
    (
        input  valid, distance, is_parallel,
        output ready
    );
endinterface

`default_nettype wire

// ----- src/lld_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lld_front
// Accepts line pairs, forms cross product and dot sums, classifies parallel.
// ----------------------------------------------------------------------------
module lld_front import lld_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    localparam int DW  = COORD_WIDTH + 1,
    localparam int PW  = 2 * DIR_W,
    localparam int NW  = PW + 1,
    localparam int DNW = DW + NW,
    localparam int AW  = DNW + 2,
    localparam int MW  = AW - 1,
    localparam int DDW = 2 * DW,
    localparam int BW  = DDW + 2,
    localparam int DAW = DW + DIR_W,
    localparam int A2W = DAW + 2,
    localparam int EW  = 1 + NN_W + BW + MW
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    lld_in_if.sink                in_ch,
    input  wire logic [CFG_W-1:0] parallel_limit,
    input  wire logic             fifo_full,
    output logic                  push,
    output logic [EW-1:0]         push_data
);

    logic en;

    logic signed [COORD_WIDTH-1:0] ao [3];
    logic signed [COORD_WIDTH-1:0] bo [3];
    logic signed [DIR_W-1:0]       da [3];
    logic signed [DIR_W-1:0]       db [3];

    logic                    v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic signed [DW-1:0]    d1_reg  [3];
    logic signed [DIR_W-1:0] da1_reg [3];
    logic signed [PW-1:0]    pa1_reg [3];
    logic signed [PW-1:0]    pb1_reg [3];
    logic signed [DW-1:0]    d2_reg  [3];
    logic signed [DIR_W-1:0] da2_reg [3];
    logic signed [NW-1:0]    n2_reg  [3];
    logic [NN_W-1:0]         nsq3_reg [3];
    logic signed [DNW-1:0]   dn3_reg  [3];
    logic signed [DDW-1:0]   dd3_reg  [3];
    logic signed [DAW-1:0]   dda3_reg [3];
    logic [NN_W-1:0]         nn4_reg;
    logic signed [AW-1:0]    acc4_reg;
    logic [BW-1:0]           accp4_reg;
    logic signed [A2W-1:0]   acc2_4_reg;
    logic                    par5_reg;
    logic [NN_W-1:0]         k5_reg;
    logic [BW-1:0]           base5_reg;
    logic [MW-1:0]           mag5_reg;

    logic                    par_next;
    logic signed [AW-1:0]    abs_src;

    assign ao = '{in_ch.a_org_x, in_ch.a_org_y, in_ch.a_org_z};
    assign bo = '{in_ch.b_org_x, in_ch.b_org_y, in_ch.b_org_z};
    assign da = '{in_ch.a_dir_x, in_ch.a_dir_y, in_ch.a_dir_z};
    assign db = '{in_ch.b_dir_x, in_ch.b_dir_y, in_ch.b_dir_z};

    // whole front pipe holds only when its last stage cannot enter the queue
    assign en          = !v5_reg || !fifo_full;
    assign in_ch.ready = en;
    assign push        = v5_reg && en;
    assign push_data   = {par5_reg, k5_reg, base5_reg, mag5_reg};

    assign par_next = nn4_reg <= NN_W'(parallel_limit);
    assign abs_src  = par_next ? AW'(acc2_4_reg) : acc4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_ch.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                // n[i] = da[i+1]*db[i+2] - da[i+2]*db[i+1]
                d1_reg[i]   <= DW'(ao[i]) - DW'(bo[i]);
                da1_reg[i]  <= da[i];
                pa1_reg[i]  <= PW'(da[(i + 1) % 3]) * PW'(db[(i + 2) % 3]);
                pb1_reg[i]  <= PW'(da[(i + 2) % 3]) * PW'(db[(i + 1) % 3]);
                d2_reg[i]   <= d1_reg[i];
                da2_reg[i]  <= da1_reg[i];
                n2_reg[i]   <= NW'(pa1_reg[i]) - NW'(pb1_reg[i]);
                nsq3_reg[i] <= NN_W'(n2_reg[i] * n2_reg[i]);
                dn3_reg[i]  <= DNW'(d2_reg[i]) * DNW'(n2_reg[i]);
                dd3_reg[i]  <= DDW'(d2_reg[i]) * DDW'(d2_reg[i]);
                dda3_reg[i] <= DAW'(d2_reg[i]) * DAW'(da2_reg[i]);
            end
            nn4_reg    <= nsq3_reg[0] + nsq3_reg[1] + nsq3_reg[2];
            acc4_reg   <= AW'(dn3_reg[0]) + AW'(dn3_reg[1]) + AW'(dn3_reg[2]);
            accp4_reg  <= BW'(unsigned'(dd3_reg[0])) + BW'(unsigned'(dd3_reg[1]))
                        + BW'(unsigned'(dd3_reg[2]));
            acc2_4_reg <= A2W'(dda3_reg[0]) + A2W'(dda3_reg[1]) + A2W'(dda3_reg[2]);
            par5_reg   <= par_next;
            k5_reg     <= par_next ? (NN_W'(1) << SCALE_SH) : nn4_reg;
            base5_reg  <= par_next ? accp4_reg : '0;
            mag5_reg   <= MW'(abs_src[AW-1] ? -abs_src : abs_src);
        end
    end

endmodule

`default_nettype wire

// ----- src/lld_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lld_fifo
// Short register queue between the classify front and the root search back.
// ----------------------------------------------------------------------------
module lld_fifo import lld_pkg::*;
#(
    parameter int W     = 8,
    parameter int DEPTH = FIFO_DEPTH,
    localparam int PTRW = $clog2(DEPTH)
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    input  wire logic [W-1:0] push_data,
    output logic              full,
    input  wire logic         pop,
    output logic [W-1:0]      pop_data,
    output logic              empty
);

    logic [W-1:0]    mem_reg [DEPTH];
    logic [PTRW-1:0] wr_reg, rd_reg;
    logic [PTRW:0]   cnt_reg;

    assign full     = cnt_reg == (PTRW + 1)'(DEPTH);
    assign empty    = cnt_reg == '0;
    assign pop_data = mem_reg[rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= (wr_reg == PTRW'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
            if (pop)
                rd_reg <= (rd_reg == PTRW'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
            cnt_reg <= cnt_reg + (PTRW + 1)'(push) - (PTRW + 1)'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= push_data;
    end

endmodule

`default_nettype wire

// ----- src/lld_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lld_back
// Squares the magnitude, forms the radicand, then one result bit per stage.
// ----------------------------------------------------------------------------
module lld_back import lld_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    localparam int MW  = COORD_WIDTH + 2 * DIR_W + 3,
    localparam int BW  = 2 * COORD_WIDTH + 4,
    localparam int EW  = 1 + NN_W + BW + MW,
    localparam int TW  = 2 * MW,
    localparam int H   = (MW + 1) / 2,
    localparam int HW  = MW - H,
    localparam int QKW = COORD_WIDTH + NN_W,
    localparam int NS  = COORD_WIDTH
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          fifo_empty,
    input  wire logic [EW-1:0] fifo_data,
    output logic               pop,
    lld_out_if.source          out_ch
);

    logic en;

    logic            e_par;
    logic [NN_W-1:0] e_k;
    logic [BW-1:0]   e_base;
    logic [MW-1:0]   e_mag;

    logic            v1_reg, v2_reg, v3_reg;
    logic            par1_reg, par2_reg, par3_reg;
    logic [NN_W-1:0] k1_reg, k2_reg, k3_reg;
    logic [BW-1:0]   base1_reg, base2_reg;
    logic [2*HW-1:0] hh1_reg;
    logic [HW+H-1:0] hl1_reg;
    logic [2*H-1:0]  ll1_reg;
    logic [TW-1:0]   sq2_reg;
    logic [TW-1:0]   tg3_reg;
    logic [TW-1:0]   radp;

    // root search stages
    logic                   vr_reg  [NS];
    logic                   pr_reg  [NS];
    logic [COORD_WIDTH-1:0] q_reg   [NS];
    logic [QKW-1:0]         qk_reg  [NS];
    logic [TW-1:0]          qqk_reg [NS];
    logic [TW-1:0]          tg_reg  [NS];
    logic [NN_W-1:0]        k_reg   [NS];

    logic [COORD_WIDTH-1:0] q_next   [NS];
    logic [QKW-1:0]         qk_next  [NS];
    logic [TW-1:0]          qqk_next [NS];
    logic [COORD_WIDTH-1:0] q_in     [NS];
    logic [QKW-1:0]         qk_in    [NS];
    logic [TW-1:0]          qqk_in   [NS];
    logic [TW-1:0]          tg_in    [NS];
    logic [NN_W-1:0]        k_in     [NS];
    logic                   v_in     [NS];
    logic                   p_in     [NS];

    assign {e_par, e_k, e_base, e_mag} = fifo_data;

    assign en  = !vr_reg[NS-1] || out_ch.ready;
    assign pop = en && !fifo_empty;

    assign out_ch.valid       = vr_reg[NS-1];
    assign out_ch.distance    = q_reg[NS-1];
    assign out_ch.is_parallel = pr_reg[NS-1];

    assign radp = TW'(base2_reg) << SCALE_SH;

    for (genvar s = 0; s < NS; s++)
    begin : g_root
        localparam int B = NS - 1 - s;
        logic [TW-1:0] cand;
        logic          take;

        if (s == 0)
        begin : g_first
            assign q_in[s]   = '0;
            assign qk_in[s]  = '0;
            assign qqk_in[s] = '0;
            assign tg_in[s]  = tg3_reg;
            assign k_in[s]   = k3_reg;
            assign v_in[s]   = v3_reg;
            assign p_in[s]   = par3_reg;
        end
        else
        begin : g_rest
            assign q_in[s]   = q_reg[s-1];
            assign qk_in[s]  = qk_reg[s-1];
            assign qqk_in[s] = qqk_reg[s-1];
            assign tg_in[s]  = tg_reg[s-1];
            assign k_in[s]   = k_reg[s-1];
            assign v_in[s]   = vr_reg[s-1];
            assign p_in[s]   = pr_reg[s-1];
        end

        // (q + 2^B)^2 k = q^2 k + 2^(B+1) qk + 2^(2B) k
        assign cand = qqk_in[s] + (TW'(qk_in[s]) << (B + 1)) + (TW'(k_in[s]) << (2 * B));
        assign take = cand <= tg_in[s];

        assign q_next[s]   = take ? (q_in[s] | (COORD_WIDTH'(1) << B)) : q_in[s];
        assign qk_next[s]  = take ? (qk_in[s] + (QKW'(k_in[s]) << B)) : qk_in[s];
        assign qqk_next[s] = take ? cand : qqk_in[s];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            for (int s = 0; s < NS; s++)
                vr_reg[s] <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= pop;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            for (int s = 0; s < NS; s++)
                vr_reg[s] <= v_in[s];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            par1_reg  <= e_par;
            k1_reg    <= e_k;
            base1_reg <= e_base;
            hh1_reg   <= (2 * HW)'(e_mag[MW-1:H]) * (2 * HW)'(e_mag[MW-1:H]);
            hl1_reg   <= (HW + H)'(e_mag[MW-1:H]) * (HW + H)'(e_mag[H-1:0]);
            ll1_reg   <= (2 * H)'(e_mag[H-1:0]) * (2 * H)'(e_mag[H-1:0]);
            par2_reg  <= par1_reg;
            k2_reg    <= k1_reg;
            base2_reg <= base1_reg;
            sq2_reg   <= (TW'(hh1_reg) << (2 * H)) + (TW'(hl1_reg) << (H + 1))
                       + TW'(ll1_reg);
            par3_reg  <= par2_reg;
            k3_reg    <= k2_reg;
            // parallel: radicand clamps at zero
            if (par2_reg)
                tg3_reg <= (radp >= sq2_reg) ? radp - sq2_reg : '0;
            else
                tg3_reg <= sq2_reg;
            for (int s = 0; s < NS; s++)
            begin
                pr_reg[s]  <= p_in[s];
                q_reg[s]   <= q_next[s];
                qk_reg[s]  <= qk_next[s];
                qqk_reg[s] <= qqk_next[s];
                tg_reg[s]  <= tg_in[s];
                k_reg[s]   <= k_in[s];
            end
        end
    end

endmodule

`default_nettype wire

// ----- src/line_line_distance_3d.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// line_line_distance_3d
// Shortest distance of two 3D lines, one transaction a clock unless stalled.
// ----------------------------------------------------------------------------
// Takes one line pair per clock when not stalled and returns one distance per
// line pair, in order. Between input and output lie five front stages, one
// queue slot, three squaring and radicand stages and one stage per result bit
// of the square root search. Throughput is one transaction per clock in
// steady state; the root search pipeline, one bit per stage, sets the latency.
// A four-entry queue sits between the front and the back, so the input keeps
// flowing for a few transactions after the output stalls.
// parallel_limit must only be written while no transaction is in flight.
// ----------------------------------------------------------------------------
module line_line_distance_3d import lld_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    lld_in_if.sink                in_ch,
    lld_out_if.source             out_ch,
    input  wire logic             cfg_we,
    input  wire logic [CFG_W-1:0] cfg_data
);

    // widths of one queue entry: parallel flag, k, base, magnitude
    localparam int MW = COORD_WIDTH + 2 * DIR_W + 3;
    localparam int BW = 2 * COORD_WIDTH + 4;
    localparam int EW = 1 + NN_W + BW + MW;

    logic [CFG_W-1:0] parallel_limit_reg;

    logic          push, pop, fifo_full, fifo_empty;
    logic [EW-1:0] push_data, pop_data;

    // configuration: threshold on |dirA x dirB|^2, units 2^-56
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            parallel_limit_reg <= '0;
        else if (cfg_we)
            parallel_limit_reg <= cfg_data;
    end

    // front: differences, cross product, dot sums, parallel test
    lld_front #(.COORD_WIDTH(COORD_WIDTH)) u_front
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_ch          (in_ch),
        .parallel_limit (parallel_limit_reg),
        .fifo_full      (fifo_full),
        .push           (push),
        .push_data      (push_data)
    );

    // decoupling queue: front and back stall on their own
    lld_fifo #(.W(EW), .DEPTH(FIFO_DEPTH)) u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (fifo_full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (fifo_empty)
    );

    // back: radicand and floored square root ratio, saturates by construction
    lld_back #(.COORD_WIDTH(COORD_WIDTH)) u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .fifo_empty (fifo_empty),
        .fifo_data  (pop_data),
        .pop        (pop),
        .out_ch     (out_ch)
    );

endmodule

`default_nettype wire

// ----- src/lld_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lld_checker
// Port level checks for the line distance block, bound to the top level.
// ----------------------------------------------------------------------------
module lld_checker import lld_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    localparam int CAP = FRONT_STAGES + FIFO_DEPTH + PRE_STAGES + COORD_WIDTH,
    localparam int CW  = $clog2(CAP + 2)
)
(
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   in_valid,
    input wire logic                   in_ready,
    input wire logic                   out_valid,
    input wire logic                   out_ready,
    input wire logic [COORD_WIDTH-1:0] distance,
    input wire logic                   is_parallel
);

    logic [CW-1:0] open_reg;
    logic          in_acc, out_acc;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    // transactions accepted but not yet delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            open_reg <= '0;
        else
            open_reg <= open_reg + CW'(in_acc) - CW'(out_acc);
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(distance) && $stable(is_parallel))
        else $error("result changed while stalled");

    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> open_reg != '0)
        else $error("result with nothing outstanding");

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        open_reg == '0 |-> in_ready)
        else $error("not ready while empty");

    a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
        open_reg <= CW'(CAP))
        else $error("more transactions in flight than storage");

endmodule

bind line_line_distance_3d lld_checker #(.COORD_WIDTH(COORD_WIDTH)) u_lld_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .distance    (out_ch.distance),
    .is_parallel (out_ch.is_parallel)
);

`default_nettype wire

// ----- tb/line_line_distance_3d_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_line_distance_3d_tb
// Streams line pairs through the distance block and checks each result
// against a bit-exact predictor, under random idling on both channels.
// ----------------------------------------------------------------------------
module line_line_distance_3d_tb;
    import lld_pkg::*;

    localparam int CW      = COORD_WIDTH_DEF;
    localparam int LATENCY = CW + 9;
    localparam int N_RAND  = 500;

    typedef struct packed {
        logic signed [CW-1:0]    aox, aoy, aoz;
        logic signed [DIR_W-1:0] adx, ady, adz;
        logic signed [CW-1:0]    box, boy, boz;
        logic signed [DIR_W-1:0] bdx, bdy, bdz;
    } line_pair_t;

    typedef struct packed {
        logic [CW-1:0] dval;
        logic          par;
    } dist_res_t;

    // One row of the directed table; chk set where the result is typed in.
    typedef struct {
        line_pair_t lp;
        logic       chk;
        dist_res_t  res;
    } dir_row_t;

    logic           clk;
    logic           rst_n;
    logic           cfg_we;
    logic [CFG_W-1:0] cfg_data;

    lld_in_if  #(.COORD_WIDTH(CW)) in_ch ();
    lld_out_if #(.COORD_WIDTH(CW)) out_ch ();

    line_line_distance_3d #(.COORD_WIDTH(CW)) dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ch    (in_ch),
        .out_ch   (out_ch),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    // Predictor copy of the register.
    logic [CFG_W-1:0] par_limit;

    dist_res_t pending_dist[$];
    int        fail_cnt;
    int        src_idle_pct;
    int        snk_idle_pct;

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Largest q < 2^CW with q*q*k <= target; 256-bit math keeps it exact.
    function automatic logic [CW-1:0] isqrt_ratio(logic [255:0] target, logic [255:0] k);
        logic [CW-1:0]  q;
        logic [CW-1:0]  t;
        logic [255:0]   tt;
        q = '0;
        for (int b = CW - 1; b >= 0; b--)
        begin
            t  = q | (CW'(1) << b);
            tt = 256'(t);
            if (tt * tt * k <= target)
                q = t;
        end
        return q;
    endfunction

    function automatic dist_res_t predict_distance(line_pair_t p);
        logic signed [63:0]  da[3], db[3], n[3], e[3];
        logic        [63:0]  nn;
        logic signed [255:0] acc, acc2, rad;
        dist_res_t           r;
        da[0] = p.adx; da[1] = p.ady; da[2] = p.adz;
        db[0] = p.bdx; db[1] = p.bdy; db[2] = p.bdz;
        n[0] = da[1] * db[2] - da[2] * db[1];
        n[1] = da[2] * db[0] - da[0] * db[2];
        n[2] = da[0] * db[1] - da[1] * db[0];
        nn = n[0] * n[0] + n[1] * n[1] + n[2] * n[2];
        acc  = '0;
        acc2 = '0;
        if (nn <= 64'(par_limit))
        begin
            // point to line: radicand in units 2^-60
            e[0] = 64'(p.box) - 64'(p.aox);
            e[1] = 64'(p.boy) - 64'(p.aoy);
            e[2] = 64'(p.boz) - 64'(p.aoz);
            for (int i = 0; i < 3; i++)
            begin
                acc  = acc + 256'(e[i]) * 256'(e[i]);
                acc2 = acc2 + 256'(e[i]) * 256'(da[i]);
            end
            rad = (acc <<< SCALE_SH) - acc2 * acc2;
            if (rad < 0)
                rad = '0;
            r.dval = isqrt_ratio(rad, 256'(1) << SCALE_SH);
            r.par  = 1'b1;
        end
        else
        begin
            e[0] = 64'(p.aox) - 64'(p.box);
            e[1] = 64'(p.aoy) - 64'(p.boy);
            e[2] = 64'(p.aoz) - 64'(p.boz);
            for (int i = 0; i < 3; i++)
                acc = acc + 256'(e[i]) * 256'(n[i]);
            if (acc < 0)
                acc = -acc;
            r.dval = isqrt_ratio(acc * acc, 256'(nn));
            r.par  = 1'b0;
        end
        return r;
    endfunction

    function automatic logic [DIR_W-1:0] rand_dir();
        case ($urandom_range(0, 9))
            0:       return DIR_W'($urandom);
            1:       return 16'sd16384;
            2:       return -16'sd16384;
            default: return DIR_W'($urandom_range(0, 32768)) - 16'sd16384;
        endcase
    endfunction

    function automatic logic [CW-1:0] rand_coord();
        case ($urandom_range(0, 5))
            0:       return CW'($urandom);
            1:       return $urandom_range(0, 1) ? {1'b0, {(CW-1){1'b1}}} : {1'b1, {(CW-1){1'b0}}};
            default: return CW'($signed(CW'($urandom_range(0, 2097152))) - 1048576);
        endcase
    endfunction

    function automatic line_pair_t rand_pair();
        line_pair_t p;
        p.aox = rand_coord(); p.aoy = rand_coord(); p.aoz = rand_coord();
        p.box = rand_coord(); p.boy = rand_coord(); p.boz = rand_coord();
        p.adx = rand_dir();   p.ady = rand_dir();   p.adz = rand_dir();
        // a third of the pairs are near parallel
        if ($urandom_range(0, 2) == 0)
        begin
            p.bdx = p.adx + DIR_W'($signed($urandom_range(0, 8)) - 4);
            p.bdy = p.ady + DIR_W'($signed($urandom_range(0, 8)) - 4);
            p.bdz = p.adz + DIR_W'($signed($urandom_range(0, 8)) - 4);
        end
        else
        begin
            p.bdx = rand_dir(); p.bdy = rand_dir(); p.bdz = rand_dir();
        end
        return p;
    endfunction

    // Drive one transaction and hold it until accepted; valid stays high
    // across back-to-back transactions.
    task automatic send_pair(line_pair_t p);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        {in_ch.a_org_x, in_ch.a_org_y, in_ch.a_org_z,
         in_ch.a_dir_x, in_ch.a_dir_y, in_ch.a_dir_z,
         in_ch.b_org_x, in_ch.b_org_y, in_ch.b_org_z,
         in_ch.b_dir_x, in_ch.b_dir_y, in_ch.b_dir_z} <= p;
        in_ch.valid <= 1'b1;
        pending_dist.push_back(predict_distance(p));
        do
            @(posedge clk);
        while (!in_ch.ready);
    endtask

    task automatic release_input();
        in_ch.valid <= 1'b0;
    endtask

    // Quiesce the block, then write the parallel threshold.
    task automatic set_limit(logic [CFG_W-1:0] v);
        release_input();
        while (pending_dist.size() != 0)
            @(posedge clk);
        repeat (LATENCY) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we   <= 1'b0;
        par_limit = v;
    endtask

    // Receiver: random stall, compare each transaction with the oldest expectation.
    always @(posedge clk)
    begin
        dist_res_t exp_r;
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (pending_dist.size() == 0)
                begin
                    $display("%0t: unexpected result dist=%h par=%b", $time,
                             out_ch.distance, out_ch.is_parallel);
                    fail_cnt++;
                end
                else
                begin
                    exp_r = pending_dist.pop_front();
                    if (out_ch.distance !== exp_r.dval)
                    begin
                        $display("%0t: distance expected %h actual %h", $time,
                                 exp_r.dval, out_ch.distance);
                        fail_cnt++;
                    end
                    if (out_ch.is_parallel !== exp_r.par)
                    begin
                        $display("%0t: is_parallel expected %b actual %b", $time,
                                 exp_r.par, out_ch.is_parallel);
                        fail_cnt++;
                    end
                end
            end
            out_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
        end
    end

    initial
    begin
        #20ms;
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        dir_row_t   rows[$];
        dir_row_t   row;
        line_pair_t p;
        dist_res_t  exp_r;

        fail_cnt     = 0;
        src_idle_pct = 30;
        snk_idle_pct = 75;
        par_limit    = '0;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_data     = '0;
        in_ch.valid  = 1'b0;
        out_ch.ready = 1'b0;
        {in_ch.a_org_x, in_ch.a_org_y, in_ch.a_org_z,
         in_ch.a_dir_x, in_ch.a_dir_y, in_ch.a_dir_z,
         in_ch.b_org_x, in_ch.b_org_y, in_ch.b_org_z,
         in_ch.b_dir_x, in_ch.b_dir_y, in_ch.b_dir_z} = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table. Identical parallel lines give 0; parallel lines
        // offset by one unit give 1.0; skew axes one unit apart give 1.0.
        p = '0; p.adx = 16384; p.bdx = 16384;
        row = '{lp: p, chk: 1'b1, res: '{dval: 0, par: 1'b1}}; rows.push_back(row);
        p.boy = 32'sh0001_0000;
        row = '{lp: p, chk: 1'b1, res: '{dval: 32'h0001_0000, par: 1'b1}}; rows.push_back(row);
        p = '0; p.adx = 16384; p.bdy = 16384; p.boz = 32'sh0001_0000;
        row = '{lp: p, chk: 1'b1, res: '{dval: 32'h0001_0000, par: 1'b0}}; rows.push_back(row);
        // Zero directions: point distance; extreme origins saturate.
        p = '0; p.aox = 32'sh8000_0000; p.box = 32'sh7fff_ffff;
        p.aoy = 32'sh8000_0000; p.boy = 32'sh7fff_ffff;
        row = '{lp: p, chk: 1'b1, res: '{dval: 32'hffff_ffff, par: 1'b1}}; rows.push_back(row);
        // Out of range directions and all-ones patterns, predictor checked.
        p = '1;
        row = '{lp: p, chk: 1'b0, res: '0}; rows.push_back(row);
        p = '0; p.adx = 16'sh8000; p.ady = 16'sh7fff; p.bdz = 16'sh8000;
        p.bdx = 16'sh7fff; p.aoz = 32'sh7fff_ffff; p.boz = 32'sh8000_0000;
        row = '{lp: p, chk: 1'b0, res: '0}; rows.push_back(row);
        // Negative radicand: non-unit direction makes the projection too large.
        p = '0; p.adx = 16'sh7fff; p.bdx = 16'sh7fff; p.box = 32'sh0010_0000;
        p.boy = 32'sh0000_0100;
        row = '{lp: p, chk: 1'b0, res: '0}; rows.push_back(row);
        for (int i = 0; i < 8; i++)
        begin
            row = '{lp: rand_pair(), chk: 1'b0, res: '0}; rows.push_back(row);
        end

        foreach (rows[i])
        begin
            if (rows[i].chk)
            begin
                exp_r = predict_distance(rows[i].lp);
                if (exp_r !== rows[i].res)
                begin
                    $display("%0t: table row %0d expected %h actual %h", $time, i,
                             rows[i].res, exp_r);
                    fail_cnt++;
                end
            end
            send_pair(rows[i].lp);
        end

        // Threshold sweep, extremes included, random traffic in each phase.
        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: set_limit(32'hffff_ffff);
                1: set_limit(32'd1);
                2: set_limit(CFG_W'($urandom_range(1, 1 << 20)));
                3: set_limit(CFG_W'($urandom));
                default: set_limit('0);
            endcase
            if (ph == 2) begin src_idle_pct = 75; snk_idle_pct = 30; end
            if (ph == 4) begin src_idle_pct = 0;  snk_idle_pct = 0;  end
            for (int i = 0; i < N_RAND / 5; i++)
                send_pair(rand_pair());
        end
        release_input();

        while (pending_dist.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        if (fail_cnt == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
